// ===== hw/rtl/range_value_count_with_swaps_defines.svh =====
// Assertion macros for the range value count block.
// Used by the checker; depends on nothing else.
`ifndef RANGE_VALUE_COUNT_WITH_SWAPS_DEFINES_SVH
`define RANGE_VALUE_COUNT_WITH_SWAPS_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define RVCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvcs assertion failed");

// Next-cycle implication, disabled while reset is high
`define RVCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvcs assertion failed");

`endif

// ===== hw/rtl/rvcs_pkg.sv =====
// Shared constants, action codes and inter-module structs for the range value count block.
// No dependencies.
`timescale 1ns / 1ps

package rvcs_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_BITS   = 10;
   localparam int COLOR_BITS  = 10;
   localparam int COUNT_BITS  = 11;
   localparam int ACTION_BITS = 2;

   // cell row: positions are interleaved, position p lives in cell p mod CELL_COUNT
   localparam int CELL_COUNT     = 8;
   localparam int CELL_BITS      = $clog2(CELL_COUNT);
   localparam int LOCAL_DEPTH    = TABLE_DEPTH / CELL_COUNT;
   localparam int LOCAL_BITS     = $clog2(LOCAL_DEPTH);
   localparam int LOCAL_CNT_BITS = $clog2(LOCAL_DEPTH + 1);

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_COUNT = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_SWAP  = 2'd2;

   // per-cell memory port controls
   typedef struct packed {
      logic                  rd_en;
      logic [LOCAL_BITS-1:0] rd_addr;
      logic                  wr_en;
      logic [LOCAL_BITS-1:0] wr_addr;
      logic [COLOR_BITS-1:0] wr_data;
   } cell_port_type;

   // scan controls broadcast to every cell
   typedef struct packed {
      logic                  clear;
      logic                  cmp_en;
      logic [LOCAL_BITS-1:0] cmp_addr;
      logic [COLOR_BITS-1:0] color;
      logic [ADDR_BITS-1:0]  lo;
      logic [ADDR_BITS-1:0]  hi;
   } scan_type;

endpackage

// ===== hw/rtl/rvcs_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on rvcs_pkg.
`timescale 1ns / 1ps

interface rvcs_req_if;
   logic                             valid;
   logic                             ready;
   logic [rvcs_pkg::ACTION_BITS-1:0] action;
   logic [rvcs_pkg::ADDR_BITS-1:0]   position;
   logic [rvcs_pkg::ADDR_BITS-1:0]   range_end;
   logic [rvcs_pkg::COLOR_BITS-1:0]  color;

   modport source (output valid, output action, output position, output range_end,
                   output color, input ready);
   modport sink   (input valid, input action, input position, input range_end,
                   input color, output ready);
endinterface

interface rvcs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rvcs_pkg::COUNT_BITS-1:0] match_count;

   modport source (output valid, output match_count, input ready);
   modport sink   (input valid, input match_count, output ready);
endinterface

// ===== hw/rtl/range_value_count_with_swaps.sv =====
// Range value count with swaps. Load writes one entry; swap reads both entries, then writes back.
// Count: all cells sweep their 128-entry banks through one registered read port each, then
// partial sums ripple down the 8-cell row.
// One item is in work at a time; a finished count waits in the output register.
// Reset (synchronous, active high) clears control state; the table is undefined until loaded.
`timescale 1ns / 1ps

module range_value_count_with_swaps (
   input  logic        clock,
   input  logic        reset,
   rvcs_req_if.sink    req_chan,
   rvcs_rsp_if.source  rsp_chan
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_SWAP  = 2'd3;

   localparam int DRAIN_LAST = rvcs_pkg::CELL_COUNT + 1;
   localparam int DRAIN_BITS = $clog2(DRAIN_LAST + 1);
   localparam logic [rvcs_pkg::LOCAL_BITS-1:0] SCAN_LAST =
      rvcs_pkg::LOCAL_BITS'(rvcs_pkg::LOCAL_DEPTH - 1);
   localparam logic [rvcs_pkg::ADDR_BITS-1:0] POS_LAST =
      rvcs_pkg::ADDR_BITS'(rvcs_pkg::TABLE_DEPTH - 1);

   logic [1:0]                          state_ff, state_in;
   logic [rvcs_pkg::LOCAL_BITS-1:0]     scan_addr_ff, scan_addr_in;
   logic                                cmp_en_ff;
   logic [rvcs_pkg::LOCAL_BITS-1:0]     cmp_addr_ff;
   logic [DRAIN_BITS-1:0]               drain_ff, drain_in;
   logic [rvcs_pkg::COLOR_BITS-1:0]     color_ff;
   logic [rvcs_pkg::ADDR_BITS-1:0]      lo_ff, hi_ff, pos_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rvcs_pkg::COUNT_BITS-1:0]     rsp_count_ff;
   logic                                accept;
   logic                                drain_done;
   logic [rvcs_pkg::ADDR_BITS-1:0]      req_next_pos, ff_next_pos;

   rvcs_pkg::cell_port_type             cell_port [rvcs_pkg::CELL_COUNT];
   rvcs_pkg::scan_type                  scan;
   logic [rvcs_pkg::COUNT_BITS-1:0]     sum_chain [rvcs_pkg::CELL_COUNT];
   logic [rvcs_pkg::COLOR_BITS-1:0]     cell_rd [rvcs_pkg::CELL_COUNT];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_next_pos   = req_chan.position + rvcs_pkg::ADDR_BITS'(1);
   assign ff_next_pos    = pos_ff + rvcs_pkg::ADDR_BITS'(1);
   assign drain_done     = (drain_ff == DRAIN_BITS'(DRAIN_LAST)) &&
                           (!rsp_valid_ff || rsp_chan.ready);

   // sequence one item at a time
   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      drain_in     = drain_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_addr_in = '0;
            drain_in     = '0;
            if (accept) begin
               if (req_chan.action == rvcs_pkg::ACT_COUNT) begin
                  state_in = ST_SCAN;
               end else if ((req_chan.action == rvcs_pkg::ACT_SWAP) &&
                            (req_chan.position != POS_LAST)) begin
                  state_in = ST_SWAP;
               end
            end
         end
         ST_SCAN: begin
            scan_addr_in = scan_addr_ff + rvcs_pkg::LOCAL_BITS'(1);
            if (scan_addr_ff == SCAN_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff != DRAIN_BITS'(DRAIN_LAST)) begin
               drain_in = drain_ff + DRAIN_BITS'(1);
            end
            if (drain_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWAP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the output until taken, load a new count when the chain has settled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DRAIN) && drain_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_addr_ff <= '0;
         drain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_en_ff    <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         scan_addr_ff <= scan_addr_in;
         drain_ff     <= drain_in;
      end
   end

   // capture the item and the scan compare address
   always_ff @(posedge clock) begin
      cmp_addr_ff <= scan_addr_ff;
      if (accept) begin
         color_ff <= req_chan.color;
         lo_ff    <= req_chan.position;
         hi_ff    <= req_chan.range_end;
         pos_ff   <= req_chan.position;
      end
      if ((state_ff == ST_DRAIN) && drain_done) begin
         rsp_count_ff <= sum_chain[rvcs_pkg::CELL_COUNT-1];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_count = rsp_count_ff;

   assign scan.clear    = accept && (req_chan.action == rvcs_pkg::ACT_COUNT);
   assign scan.cmp_en   = cmp_en_ff;
   assign scan.cmp_addr = cmp_addr_ff;
   assign scan.color    = color_ff;
   assign scan.lo       = lo_ff;
   assign scan.hi       = hi_ff;

   // drive the row of cells
   for (genvar k = 0; k < rvcs_pkg::CELL_COUNT; k++) begin : g_cell
      localparam logic [rvcs_pkg::CELL_BITS-1:0] CELL_ID = rvcs_pkg::CELL_BITS'(k);
      logic [rvcs_pkg::COUNT_BITS-1:0] sum_prev;

      always_comb begin
         cell_port[k] = '0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_chan.action == rvcs_pkg::ACT_LOAD) &&
                   (req_chan.position[rvcs_pkg::CELL_BITS-1:0] == CELL_ID)) begin
                  cell_port[k].wr_en   = 1'b1;
                  cell_port[k].wr_addr =
                     req_chan.position[rvcs_pkg::ADDR_BITS-1:rvcs_pkg::CELL_BITS];
                  cell_port[k].wr_data = req_chan.color;
               end
               // read both sides of a swap
               if (accept && (req_chan.action == rvcs_pkg::ACT_SWAP)) begin
                  if (req_chan.position[rvcs_pkg::CELL_BITS-1:0] == CELL_ID) begin
                     cell_port[k].rd_en   = 1'b1;
                     cell_port[k].rd_addr =
                        req_chan.position[rvcs_pkg::ADDR_BITS-1:rvcs_pkg::CELL_BITS];
                  end else if (req_next_pos[rvcs_pkg::CELL_BITS-1:0] == CELL_ID) begin
                     cell_port[k].rd_en   = 1'b1;
                     cell_port[k].rd_addr =
                        req_next_pos[rvcs_pkg::ADDR_BITS-1:rvcs_pkg::CELL_BITS];
                  end
               end
            end
            ST_SCAN: begin
               cell_port[k].rd_en   = 1'b1;
               cell_port[k].rd_addr = scan_addr_ff;
            end
            ST_SWAP: begin
               // write each side back with the other's color
               if (pos_ff[rvcs_pkg::CELL_BITS-1:0] == CELL_ID) begin
                  cell_port[k].wr_en   = 1'b1;
                  cell_port[k].wr_addr = pos_ff[rvcs_pkg::ADDR_BITS-1:rvcs_pkg::CELL_BITS];
                  cell_port[k].wr_data = cell_rd[ff_next_pos[rvcs_pkg::CELL_BITS-1:0]];
               end else if (ff_next_pos[rvcs_pkg::CELL_BITS-1:0] == CELL_ID) begin
                  cell_port[k].wr_en   = 1'b1;
                  cell_port[k].wr_addr =
                     ff_next_pos[rvcs_pkg::ADDR_BITS-1:rvcs_pkg::CELL_BITS];
                  cell_port[k].wr_data = cell_rd[pos_ff[rvcs_pkg::CELL_BITS-1:0]];
               end
            end
            default: begin
               cell_port[k] = '0;
            end
         endcase
      end

      if (k == 0) begin : g_head
         assign sum_prev = '0;
      end else begin : g_link
         assign sum_prev = sum_chain[k-1];
      end

      rvcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CELL_ID),
         .port       (cell_port[k]),
         .scan       (scan),
         .sum_in     (sum_prev),
         .sum_out    (sum_chain[k]),
         .rd_data    (cell_rd[k])
      );
   end

endmodule

// ===== hw/rtl/rvcs_cell.sv =====
// One cell of the row: a bank of the color table, a local match counter and
// one stage of the partial-sum chain. Depends on rvcs_pkg.
`timescale 1ns / 1ps

module rvcs_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rvcs_pkg::CELL_BITS-1:0]    cell_index,
   input  rvcs_pkg::cell_port_type           port,
   input  rvcs_pkg::scan_type                scan,
   input  logic [rvcs_pkg::COUNT_BITS-1:0]   sum_in,
   output logic [rvcs_pkg::COUNT_BITS-1:0]   sum_out,
   output logic [rvcs_pkg::COLOR_BITS-1:0]   rd_data
);

   logic [rvcs_pkg::COLOR_BITS-1:0]     mem [rvcs_pkg::LOCAL_DEPTH];
   logic [rvcs_pkg::COLOR_BITS-1:0]     rd_data_ff;
   logic [rvcs_pkg::LOCAL_CNT_BITS-1:0] cnt_ff;
   logic [rvcs_pkg::LOCAL_CNT_BITS-1:0] cnt_in;
   logic [rvcs_pkg::COUNT_BITS-1:0]     sum_ff;
   logic [rvcs_pkg::COUNT_BITS-1:0]     sum_in_val;
   logic [rvcs_pkg::ADDR_BITS-1:0]      gpos;
   logic                                hit;

   // write and registered read of the bank
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= mem[port.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // match the entry read last cycle against color and range
   assign gpos = {scan.cmp_addr, cell_index};
   assign hit  = scan.cmp_en && (rd_data_ff == scan.color) &&
                 (gpos >= scan.lo) && (gpos <= scan.hi);

   always_comb begin
      cnt_in = cnt_ff;
      if (scan.clear) begin
         cnt_in = '0;
      end else if (hit) begin
         cnt_in = cnt_ff + rvcs_pkg::LOCAL_CNT_BITS'(1);
      end
   end

   // add the local count to the neighbor's partial sum and pass it on
   assign sum_in_val = sum_in + rvcs_pkg::COUNT_BITS'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in_val;
      end
   end

   assign sum_out = sum_ff;

endmodule

// ===== hw/rtl/rvcs_checker.sv =====
// Port-level assertions for the range value count block, bound to the top level.
// Depends on rvcs_pkg and range_value_count_with_swaps_defines.svh.
`timescale 1ns / 1ps
`include "range_value_count_with_swaps_defines.svh"

module rvcs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [rvcs_pkg::ACTION_BITS-1:0] req_action,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rvcs_pkg::COUNT_BITS-1:0]  rsp_match_count
);

   logic req_xfer;

   assign req_xfer = req_valid && req_ready;

   // a stalled response holds its count
   `RVCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_match_count))

   // a count never exceeds the table size
   `RVCS_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_match_count <= rvcs_pkg::COUNT_BITS'(rvcs_pkg::TABLE_DEPTH))

   // a count transfer starts a scan, so the block is busy next cycle
   `RVCS_ASSERT_NEXT(a_count_busy, clock, reset, req_xfer && (req_action == rvcs_pkg::ACT_COUNT), !req_ready)

   // a load finishes in its own cycle
   `RVCS_ASSERT_NEXT(a_load_quick, clock, reset, req_xfer && (req_action == rvcs_pkg::ACT_LOAD), req_ready)

endmodule

bind range_value_count_with_swaps rvcs_checker u_rvcs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_action      (req_chan.action),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_match_count (rsp_chan.match_count)
);
